[rtl/pf6_pkg.sv]
package pf6_pkg;

  localparam int NSYM  = 36;
  localparam int SIDE  = 6;
  localparam int SYM_W = 6;

  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_Z  = 8'h5A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [SYM_W-1:0] SYM_X      = 6'd23;
  localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd26;
  localparam logic [2:0] LAST_COL = 3'd5;
  localparam logic [2:0] ROW_FULL = 3'd6;

  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] code;
  } sym_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // Status that each cell of the symbol chain reports to the controller.
  typedef struct packed {
    logic             match;
    logic             avail;
    logic [SYM_W-1:0] sym;
  } cell_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  function automatic sym_t sym_of(input logic [7:0] c);
    sym_t r;
    logic [7:0] d;
    r = '0;
    if (c >= CH_A && c <= CH_Z) begin
      d = c - CH_A;
      r.ok = 1'b1;
      r.code = d[SYM_W-1:0];
    end else if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      r.ok = 1'b1;
      r.code = DIGIT_BASE + d[SYM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] ascii_of(input logic [SYM_W-1:0] s);
    logic [7:0] r;
    if (s < DIGIT_BASE) begin
      r = CH_A + {2'b00, s};
    end else begin
      r = CH_0 + {2'b00, s - DIGIT_BASE};
    end
    return r;
  endfunction

  // Row-major cell index: row * 6 + col.
  function automatic logic [SYM_W-1:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
    return {1'b0, row, 2'b00} + {2'b00, row, 1'b0} + {3'b000, col};
  endfunction

endpackage

[rtl/pf6_cell.sv]
module pf6_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pf6_pkg::SYM_W-1:0]    idx_i,
  input  logic                         set_en_i,
  input  logic [pf6_pkg::SYM_W-1:0]    set_sym_i,
  input  logic                         clr_i,
  input  logic                         tok_i,
  output logic                         tok_o,
  output pf6_pkg::cell_st_t            st_o
);

  logic used_r;
  logic used_nxt;
  logic tok_r;
  logic hit;

  assign hit = (set_sym_i == idx_i);

  always_comb begin
    used_nxt = used_r;
    if (clr_i) begin
      used_nxt = 1'b0;
    end else if (set_en_i && hit) begin
      used_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_i;
    end
  end

  assign tok_o       = tok_r;
  assign st_o.match  = used_r & hit;
  assign st_o.avail  = tok_r & ~used_r;
  assign st_o.sym    = tok_r ? idx_i : '0;

endmodule

[rtl/pf6_ram.sv]
module pf6_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pf6_pkg::SYM_W-1:0]    wa,
  input  logic [pf6_pkg::SYM_W-1:0]    wd,
  input  logic                         re,
  input  logic [pf6_pkg::SYM_W-1:0]    ra0,
  input  logic [pf6_pkg::SYM_W-1:0]    ra1,
  output logic [pf6_pkg::SYM_W-1:0]    rd0,
  output logic [pf6_pkg::SYM_W-1:0]    rd1
);

  logic [pf6_pkg::SYM_W-1:0] mem [pf6_pkg::NSYM];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

endmodule

[rtl/playfair_6x6_cipher_unit.sv]
// A text beat that completes a pair reads the position memory at its accepting edge and the
// square memory in the cycle after, in ST_LOOK; the first result beat is offered in ST_EMIT1.
// No new input beat is taken until the result beats have been emitted and the unit is idle
// again. Other text and key beats leave it idle. A key beat with last_in starts the fill:
// a token walks the 36 symbol cells, one per cycle; no beat is taken until it passes the last.
// Synchronous reset (rst_n low) clears control state, used-symbol cells and decode mode only.
module playfair_6x6_cipher_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pf6_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pf6_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  pf6_pkg::state_t   state_r, state_nxt;
  logic              decode_r;
  logic              held_v_r, held_v_nxt;
  logic [pf6_pkg::SYM_W-1:0] held_sym_r, held_sym_nxt;
  logic              last_r, last_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [2:0]        col_r, col_nxt;

  pf6_pkg::sym_t     ks, ts;
  pf6_pkg::cell_st_t st [pf6_pkg::NSYM];
  logic [pf6_pkg::NSYM-1:0] tok_v;
  logic              inject, clr, set_en, full;
  logic              match_any, avail_any;
  logic [pf6_pkg::SYM_W-1:0] fill_sym, set_sym;

  logic              pos_re, sq_re;
  logic [pf6_pkg::SYM_W-1:0] pos_ra0, pos_ra1, pos_rd0, pos_rd1;
  logic [pf6_pkg::SYM_W-1:0] sq_ra0, sq_ra1, sq_rd0, sq_rd1;
  pf6_pkg::pos_t     pa, pb;
  logic              drop;

  assign cfg_ready = 1'b1;
  assign ks = pf6_pkg::sym_of(in_data.char_in);
  assign ts = pf6_pkg::sym_of(pf6_pkg::to_upper(in_data.char_in));
  assign full = (row_r == pf6_pkg::ROW_FULL);
  assign set_sym = (state_r == pf6_pkg::ST_FILL) ? fill_sym : ks.code;

  genvar g;
  generate
    for (g = 0; g < pf6_pkg::NSYM; g++) begin : g_cell
      logic tok_in;
      if (g == 0) begin : g_head
        assign tok_in = inject;
      end else begin : g_body
        assign tok_in = tok_v[g-1];
      end
      pf6_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx_i     (pf6_pkg::SYM_W'(g)),
        .set_en_i  (set_en),
        .set_sym_i (set_sym),
        .clr_i     (clr),
        .tok_i     (tok_in),
        .tok_o     (tok_v[g]),
        .st_o      (st[g])
      );
    end
  endgenerate

  always_comb begin
    match_any = 1'b0;
    avail_any = 1'b0;
    fill_sym  = '0;
    for (int s = 0; s < pf6_pkg::NSYM; s++) begin
      match_any = match_any | st[s].match;
      avail_any = avail_any | st[s].avail;
      fill_sym  = fill_sym | st[s].sym;
    end
  end

  // Square memory: cell index -> symbol. Position memory: symbol -> row and column.
  pf6_ram u_sq (
    .clk (clk),
    .we  (set_en),
    .wa  (pf6_pkg::cell_idx(row_r, col_r)),
    .wd  (set_sym),
    .re  (sq_re),
    .ra0 (sq_ra0),
    .ra1 (sq_ra1),
    .rd0 (sq_rd0),
    .rd1 (sq_rd1)
  );

  pf6_ram u_pos (
    .clk (clk),
    .we  (set_en),
    .wa  (set_sym),
    .wd  ({row_r, col_r}),
    .re  (pos_re),
    .ra0 (pos_ra0),
    .ra1 (pos_ra1),
    .rd0 (pos_rd0),
    .rd1 (pos_rd1)
  );

  assign pa = pf6_pkg::pos_t'(pos_rd0);
  assign pb = pf6_pkg::pos_t'(pos_rd1);
  assign drop = last_r & decode_r & (sq_rd1 == pf6_pkg::SYM_X);

  always_comb begin
    state_nxt    = state_r;
    held_v_nxt   = held_v_r;
    held_sym_nxt = held_sym_r;
    last_nxt     = last_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    out_data     = '0;
    inject       = 1'b0;
    clr          = 1'b0;
    set_en       = 1'b0;
    pos_re       = 1'b0;
    pos_ra0      = ts.code;
    pos_ra1      = pf6_pkg::SYM_X;
    sq_re        = 1'b0;
    sq_ra0       = pf6_pkg::cell_idx(pa.row, pb.col);
    sq_ra1       = pf6_pkg::cell_idx(pb.row, pa.col);
    unique case (state_r)
      pf6_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_data.action) begin
            set_en = ks.ok & ~match_any & ~full;
            if (in_data.last_in) begin
              inject    = 1'b1;
              state_nxt = pf6_pkg::ST_FILL;
            end
          end else begin
            last_nxt = in_data.last_in;
            if (ts.ok) begin
              if (!held_v_r) begin
                if (in_data.last_in) begin
                  pos_re    = 1'b1;
                  state_nxt = pf6_pkg::ST_LOOK;
                end else begin
                  held_sym_nxt = ts.code;
                  held_v_nxt   = 1'b1;
                end
              end else begin
                pos_re     = 1'b1;
                pos_ra0    = held_sym_r;
                pos_ra1    = ts.code;
                held_v_nxt = 1'b0;
                state_nxt  = pf6_pkg::ST_LOOK;
              end
            end else if (in_data.last_in && held_v_r) begin
              // A dropped character that ends the text flushes the held one with X.
              pos_re     = 1'b1;
              pos_ra0    = held_sym_r;
              held_v_nxt = 1'b0;
              state_nxt  = pf6_pkg::ST_LOOK;
            end
          end
        end
      end
      pf6_pkg::ST_FILL: begin
        set_en = avail_any & ~full;
        if (tok_v[pf6_pkg::NSYM-1]) begin
          clr       = 1'b1;
          state_nxt = pf6_pkg::ST_IDLE;
        end
      end
      pf6_pkg::ST_LOOK: begin
        sq_re     = 1'b1;
        state_nxt = pf6_pkg::ST_EMIT1;
      end
      pf6_pkg::ST_EMIT1: begin
        out_valid         = 1'b1;
        out_data.char_out = pf6_pkg::ascii_of(sq_rd0);
        out_data.last_out = drop;
        if (out_ready) begin
          state_nxt = drop ? pf6_pkg::ST_IDLE : pf6_pkg::ST_EMIT2;
        end
      end
      pf6_pkg::ST_EMIT2: begin
        out_valid         = 1'b1;
        out_data.char_out = pf6_pkg::ascii_of(sq_rd1);
        out_data.last_out = last_r;
        if (out_ready) begin
          state_nxt = pf6_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pf6_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (clr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (set_en) begin
      if (col_r == pf6_pkg::LAST_COL) begin
        col_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pf6_pkg::ST_IDLE;
      decode_r <= 1'b0;
      held_v_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      held_v_r <= held_v_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      if (cfg_valid && cfg_ready) begin
        decode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_sym_r <= held_sym_nxt;
    last_r     <= last_nxt;
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v))
    else $error("more than one fill token in the symbol chain");

  a_token_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_v) |-> (state_r == pf6_pkg::ST_FILL))
    else $error("fill token outside the fill phase");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= pf6_pkg::ROW_FULL) && ((row_r != pf6_pkg::ROW_FULL) || (col_r == 3'd0)))
    else $error("fill pointer out of the square");

  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf6_pkg::ST_FILL && tok_v[pf6_pkg::NSYM-1]) |=>
      (state_r == pf6_pkg::ST_IDLE && row_r == 3'd0 && col_r == 3'd0))
    else $error("key fill did not finish with a cleared pointer");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf6_pkg::ST_EMIT1 && out_ready && !drop) |=> (state_r == pf6_pkg::ST_EMIT2))
    else $error("second result of a pair was skipped");

endmodule

[dv/playfair_6x6_cipher_unit_test.sv]
module playfair_6x6_cipher_unit_test;

  localparam bit ACT_KEY = 1'b0;
  localparam bit ACT_TEXT = 1'b1;
  localparam logic [7:0] PAD_CHAR = 8'h58;
  localparam int CYCLE_LIMIT = 400_000;
  // A key beat with last_in keeps the block busy while the fill token walks the symbol cells.
  localparam int SETTLE_CYCLES = 48;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pf6_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  pf6_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  playfair_6x6_cipher_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  class cipher_scoreboard;
    logic [pf6_pkg::SYM_W-1:0] square [pf6_pkg::NSYM];
    logic [pf6_pkg::SYM_W-1:0] where [pf6_pkg::NSYM];
    logic [pf6_pkg::NSYM-1:0] used;
    int fill;
    logic [7:0] held_char;
    bit held_ok;
    bit decode;
    pf6_pkg::out_t cipher_due [$];
    int errors;
    int beats_checked;
    int x_drops;

    function new();
      foreach (square[i]) begin
        square[i] = '0;
        where[i] = '0;
      end
      used = '0;
      fill = 0;
      held_char = '0;
      held_ok = 1'b0;
      decode = 1'b0;
      errors = 0;
      beats_checked = 0;
      x_drops = 0;
    endfunction

    // Symbol code of an upper-case letter or digit; NSYM for anything else.
    static function int sym_code(logic [7:0] c);
      if (c >= pf6_pkg::CH_A && c <= pf6_pkg::CH_Z) return int'(c) - int'(pf6_pkg::CH_A);
      if (c >= pf6_pkg::CH_0 && c <= pf6_pkg::CH_9)
        return int'(pf6_pkg::DIGIT_BASE) + int'(c) - int'(pf6_pkg::CH_0);
      return pf6_pkg::NSYM;
    endfunction

    static function logic [7:0] code_char(int s);
      if (s < int'(pf6_pkg::DIGIT_BASE)) return 8'(int'(pf6_pkg::CH_A) + s);
      return 8'(int'(pf6_pkg::CH_0) + s - int'(pf6_pkg::DIGIT_BASE));
    endfunction

    function void place(int s);
      if (s >= pf6_pkg::NSYM || used[s] || fill >= pf6_pkg::NSYM) return;
      square[fill] = pf6_pkg::SYM_W'(s);
      where[s] = pf6_pkg::SYM_W'(fill);
      used[s] = 1'b1;
      fill++;
    endfunction

    function void cipher_pair(logic [7:0] a, logic [7:0] b, bit last);
      int pa;
      int pb;
      logic [7:0] c2;
      pf6_pkg::out_t beat;
      pa = int'(where[sym_code(a)]);
      pb = int'(where[sym_code(b)]);
      beat.char_out = code_char(int'(square[(pa / pf6_pkg::SIDE) * pf6_pkg::SIDE
                                             + pb % pf6_pkg::SIDE]));
      beat.last_out = 1'b0;
      c2 = code_char(int'(square[(pb / pf6_pkg::SIDE) * pf6_pkg::SIDE + pa % pf6_pkg::SIDE]));
      if (last && decode && c2 == PAD_CHAR) begin
        beat.last_out = 1'b1;
        cipher_due.push_back(beat);
        x_drops++;
        return;
      end
      cipher_due.push_back(beat);
      beat.char_out = c2;
      beat.last_out = last;
      cipher_due.push_back(beat);
    endfunction

    function void take_plain_beat(pf6_pkg::in_t it);
      logic [7:0] c;
      c = it.char_in;
      if (it.action == ACT_KEY) begin
        place(sym_code(c));
        if (it.last_in) begin
          for (int k = 0; k < pf6_pkg::NSYM; k++) place(k);
          used = '0;
          fill = 0;
        end
        return;
      end
      if (c >= pf6_pkg::CH_LA && c <= pf6_pkg::CH_LZ) c = c - 8'h20;
      if (sym_code(c) < pf6_pkg::NSYM) begin
        if (!held_ok) begin
          if (it.last_in) cipher_pair(c, PAD_CHAR, 1'b1);
          else begin
            held_char = c;
            held_ok = 1'b1;
          end
        end else begin
          held_ok = 1'b0;
          cipher_pair(held_char, c, it.last_in);
        end
      end else if (it.last_in && held_ok) begin
        held_ok = 1'b0;
        cipher_pair(held_char, PAD_CHAR, 1'b1);
      end
    endfunction

    function void check_cipher_beat(pf6_pkg::out_t got);
      pf6_pkg::out_t want;
      if (cipher_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result beat: expected none, actual char_out=%h last_out=%b",
                   $time, got.char_out, got.last_out);
        errors++;
        return;
      end
      want = cipher_due.pop_front();
      beats_checked++;
      if (got.char_out !== want.char_out) begin
        if (errors < MAX_REPORTS)
          $display("%0t: char_out mismatch: expected %h, actual %h",
                   $time, want.char_out, got.char_out);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        if (errors < MAX_REPORTS)
          $display("%0t: last_out mismatch: expected %b, actual %b",
                   $time, want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  cipher_scoreboard sb = new();
  bit stall_on = 1'b1;
  int items_sent = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    return stall_on ? int'($urandom_range(0, 3)) : 0;
  endfunction

  task automatic send_item(input bit act, input logic [7:0] c, input bit last);
    int gap;
    pf6_pkg::in_t it;
    it.action = act;
    it.char_in = c;
    it.last_in = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.take_plain_beat(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    while (sb.cipher_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_decode(input bit mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.decode = mode;
  endtask

  function automatic logic [7:0] rand_symbol_char(input bit allow_lower);
    logic [7:0] c;
    c = cipher_scoreboard::code_char(int'($urandom_range(0, pf6_pkg::NSYM - 1)));
    if (allow_lower && c >= pf6_pkg::CH_A && c <= pf6_pkg::CH_Z && $urandom_range(0, 1) == 1)
      c = c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_key_char();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : rand_symbol_char(1'b0);
  endfunction

  function automatic logic [7:0] rand_text_char();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : rand_symbol_char(1'b1);
  endfunction

  // Ends a text run with a pair whose second result is the pad letter, so that
  // decode mode has to drop it.
  task automatic x_ending(input bit pad);
    int xpos;
    int xr;
    int xc;
    if (sb.held_ok) send_item(ACT_TEXT, rand_symbol_char(1'b1), 1'b0);
    xpos = int'(sb.where[pf6_pkg::SYM_X]);
    xr = xpos / pf6_pkg::SIDE;
    xc = xpos % pf6_pkg::SIDE;
    send_item(ACT_TEXT,
              cipher_scoreboard::code_char(
                int'(sb.square[int'($urandom_range(0, 5)) * pf6_pkg::SIDE + xc])),
              pad);
    if (!pad)
      send_item(ACT_TEXT,
                cipher_scoreboard::code_char(
                  int'(sb.square[xr * pf6_pkg::SIDE + int'($urandom_range(0, 5))])),
                1'b1);
  endtask

  task automatic send_key_run();
    int n;
    n = $urandom_range(0, 10);
    repeat (n) send_item(ACT_KEY, rand_key_char(), 1'b0);
    send_item(ACT_KEY,
              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : rand_symbol_char(1'b0),
              1'b1);
  endtask

  task automatic send_text_run(input bit close);
    int n;
    n = $urandom_range(0, 15);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0)
        send_item(ACT_KEY, rand_key_char(), $urandom_range(0, 19) == 0);
      send_item(ACT_TEXT, rand_text_char(), 1'b0);
    end
    if (close) begin
      if ($urandom_range(0, 2) == 0) x_ending(1'($urandom_range(0, 1)));
      else
        send_item(ACT_TEXT,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : rand_symbol_char(1'b1),
                  1'b1);
    end
  endtask

  task automatic directed_items();
    // Key with repeats and characters that must be ignored, closed by an invalid one.
    send_item(ACT_KEY, "Z", 1'b0);
    send_item(ACT_KEY, "9", 1'b0);
    send_item(ACT_KEY, "A", 1'b0);
    send_item(ACT_KEY, "0", 1'b0);
    send_item(ACT_KEY, 8'h00, 1'b0);
    send_item(ACT_KEY, 8'hFF, 1'b0);
    send_item(ACT_KEY, "q", 1'b0);
    send_item(ACT_KEY, "Z", 1'b0);
    send_item(ACT_KEY, "#", 1'b1);
    send_item(ACT_TEXT, "a", 1'b0);
    send_item(ACT_TEXT, "0", 1'b0);
    send_item(ACT_TEXT, "z", 1'b0);
    send_item(ACT_TEXT, 8'hFF, 1'b0);
    send_item(ACT_TEXT, "9", 1'b0);
    // A key beat while a text character is held starts a new key.
    send_item(ACT_TEXT, "B", 1'b0);
    send_item(ACT_KEY, "C", 1'b0);
    send_item(ACT_TEXT, "X", 1'b0);
    send_item(ACT_KEY, "#", 1'b1);
    send_item(ACT_TEXT, "Q", 1'b1);
    send_item(ACT_TEXT, "M", 1'b0);
    send_item(ACT_TEXT, "!", 1'b1);
    send_item(ACT_TEXT, ".", 1'b1);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_cipher_beat(out_data);
    end
  end

  initial begin
    int phase_start;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_decode(1'(ph % 2));
      stall_on = (ph % 3 != 2);
      phase_start = items_sent;
      if (ph == 0) directed_items();
      if (ph == 1) begin
        x_ending(1'b0);
        x_ending(1'b1);
      end
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 3) != 0) send_key_run();
        send_text_run($urandom_range(0, 9) != 0);
      end
      in_valid <= 1'b0;
    end
    wait_idle();
    $display("Ran %0d input beats over %0d phases alternating encode and decode;",
             items_sent, NUM_PHASES);
    $display("%0d result beats checked, %0d trailing pad letters dropped, %0d failures seen.",
             sb.beats_checked, sb.x_drops, sb.errors);
    if (sb.errors == 0 && sb.cipher_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[playfair_6x6_cipher_unit.f]
rtl/pf6_pkg.sv
rtl/pf6_cell.sv
rtl/pf6_ram.sv
rtl/playfair_6x6_cipher_unit.sv
dv/playfair_6x6_cipher_unit_test.sv
